### rtl/core/mpd_pkg.sv
// Package for the maglev plant derivative block: widths, register indexes,
// reset values and the structs used by the top level and the divider.
// Depends on nothing.
`default_nettype none

package mpd_pkg;

    localparam int DATA_W    = 32;
    localparam int PAR_W     = 31;
    localparam int OUT_W     = 48;
    localparam int NUM_W     = 128;
    localparam int DEN_W     = 98;
    localparam int Q_W       = 64;
    localparam int DIV_STEPS = NUM_W;
    localparam int SIDE_LEN  = DIV_STEPS + 2;
    localparam int CFG_IDX_W = 3;
    localparam int BASE_W    = 38;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESISTANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L_FAR      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_XI         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER      = 3'd7;

    localparam logic [PAR_W-1:0] RST_GRAVITY    = 31'd164584489;
    localparam logic [PAR_W-1:0] RST_MASS       = 31'd13421773;
    localparam logic [PAR_W-1:0] RST_RESISTANCE = 31'd195957883;
    localparam logic [PAR_W-1:0] RST_OFFSET     = 31'd117441;
    localparam logic [PAR_W-1:0] RST_L_FAR      = 31'd13509014;
    localparam logic [PAR_W-1:0] RST_XI         = 31'd26827;
    localparam logic [PAR_W-1:0] RST_UPPER      = 31'd218104;

    localparam logic [61:0] Q_LIM = {1'b1, 61'd0};

    typedef struct packed {
        logic             neg;
        logic             zero;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_in;

    typedef struct packed {
        logic                     mode;
        logic                     dle0;
        logic                     dgeu;
        logic signed [DATA_W-1:0] dd;
        logic [BASE_W-1:0]        base_m;
        logic signed [DATA_W-1:0] v;
    } t_side;

endpackage

`default_nettype wire

### rtl/core/mpd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with rounding
// half away from zero and clipping to 2^61. Depends on mpd_pkg.
`default_nettype none

module mpd_div
    import mpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  t_div_in               i_div,
    output logic signed [Q_W-1:0] o_quot
);

    logic [DEN_W-1:0] r_rem  [0:DIV_STEPS];
    logic [NUM_W-1:0] r_sh   [0:DIV_STEPS];
    logic [DEN_W-1:0] r_den  [0:DIV_STEPS];
    logic             r_neg  [0:DIV_STEPS];
    logic             r_zero [0:DIV_STEPS];
    logic signed [Q_W-1:0] r_quot;

    logic [DEN_W:0]   n_trial [1:DIV_STEPS];
    logic             n_ge    [1:DIV_STEPS];
    logic [DEN_W-1:0] n_rem   [1:DIV_STEPS];
    logic [NUM_W-1:0] n_sh    [1:DIV_STEPS];

    logic                  n_round;
    logic [62:0]           n_qr;
    logic                  n_over;
    logic [61:0]           n_mag;
    logic signed [Q_W-1:0] n_quot;

    always_comb begin
        for (int k = 1; k <= DIV_STEPS; k++) begin
            n_trial[k] = {r_rem[k-1], r_sh[k-1][NUM_W-1]};
            n_ge[k]    = n_trial[k] >= {1'b0, r_den[k-1]};
            n_rem[k]   = n_ge[k] ? DEN_W'(n_trial[k] - {1'b0, r_den[k-1]})
                                 : n_trial[k][DEN_W-1:0];
            n_sh[k]    = {r_sh[k-1][NUM_W-2:0], n_ge[k]};
        end
    end

    always_comb begin
        n_round = {r_rem[DIV_STEPS], 1'b0} >= {1'b0, r_den[DIV_STEPS]};
        n_qr    = {1'b0, r_sh[DIV_STEPS][61:0]} + {62'd0, n_round};
        n_over  = (|r_sh[DIV_STEPS][NUM_W-1:62]) || (n_qr > {1'b0, Q_LIM});
        n_mag   = n_over ? Q_LIM : n_qr[61:0];
        if (r_zero[DIV_STEPS]) begin
            n_quot = '0;
        end else if (r_neg[DIV_STEPS]) begin
            n_quot = -$signed({2'b00, n_mag});
        end else begin
            n_quot = $signed({2'b00, n_mag});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_sh[0]   <= i_div.num;
            r_den[0]  <= i_div.den;
            r_neg[0]  <= i_div.neg;
            r_zero[0] <= i_div.zero;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_sh[k]   <= n_sh[k];
                r_den[k]  <= r_den[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
            end
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

### rtl/core/maglev_plant_derivative.sv
// Maglev plant derivative: fixed-point time derivatives of gap, motion and
// coil current, with end stops. Depends on mpd_pkg and mpd_div.
//
//   channel  direction  handshake                       payload
//   s_axis   in         i_s_axis_tvalid/o_s_axis_tready  position, motion, current, voltage
//   m_axis   out        o_m_axis_tvalid/i_m_axis_tready  position_rate, motion_rate, current_rate
//   cfg      in         i_cfg_we                         i_cfg_addr, i_cfg_wdata
//
// One item is accepted every cycle while the output is not stalled; each item
// passes through the input stages and the three 130-stage divider pipelines.
// Reset clears the valid bits and loads the register reset values.
// A stall at the output freezes every stage; nothing is lost or repeated.
`default_nettype none

module maglev_plant_derivative
    import mpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // position [31:0], motion [63:32], current [95:64], voltage [127:96]
    input  logic [127:0]         i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // position_rate [47:0], motion_rate [95:48], current_rate [143:96]
    output logic [143:0]         o_m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [PAR_W-1:0]     i_cfg_wdata
);

    localparam logic signed [65:0] SAT_HI = 66'sd140737488355327;
    localparam logic signed [65:0] SAT_LO = -66'sd140737488355328;

    function automatic logic [31:0] f_abs32(input logic [31:0] a);
        return a[31] ? 32'(~a + 32'd1) : a;
    endfunction

    function automatic logic signed [OUT_W-1:0] f_sat(input logic signed [65:0] a);
        if (a > SAT_HI) begin
            return SAT_HI[OUT_W-1:0];
        end else if (a < SAT_LO) begin
            return SAT_LO[OUT_W-1:0];
        end
        return a[OUT_W-1:0];
    endfunction

    logic             r_mode;
    logic [PAR_W-1:0] r_gravity, r_mass, r_res, r_offset, r_lfar, r_xi, r_upper;

    logic adv;
    logic [7:1] r_vld;
    logic       r_svld [0:SIDE_LEN-1];
    t_side      r_side [0:SIDE_LEN-1];
    t_side      n_side;
    logic       r_o_vld;
    logic signed [OUT_W-1:0] r_o_pr, r_o_mr, r_o_cr;

    // stage 1
    logic signed [31:0] r_d1, r_dd1, r_i1, r_v1;
    // stage 2
    logic signed [32:0] n_x2;
    logic [31:0] r_ax2, r_ai2, r_add2, r_av2;
    logic        r_xn2, r_in2, r_ddn2, r_vn2, r_dle2, r_dgeu2;
    logic signed [31:0] r_dd2, r_v2;
    // stage 3
    logic [63:0] r_xx3, r_ii3, r_xv3, r_ix3;
    logic [62:0] r_lx3, r_xidd3;
    logic [61:0] r_mg3;
    logic [31:0] r_ax3, r_add3;
    logic        r_xn3, r_in3, r_ddn3, r_vn3, r_dle3, r_dgeu3;
    logic signed [31:0] r_dd3, r_v3;
    // stage 4
    logic [63:0] n_xi24, n_lx4, n_w4;
    logic        n_wn4;
    logic [63:0] r_w4;
    logic        r_wn4;
    logic [62:0] r_xxm_l4, r_xxm_h4, r_xxr_l4, r_xxr_h4;
    logic [62:0] r_iix_l4, r_iix_h4, r_ixr_l4, r_ixr_h4;
    logic [BASE_W-1:0] r_mg4;
    logic [62:0] r_xidd4;
    logic [63:0] r_xv4;
    logic [31:0] r_ax4, r_add4;
    logic        r_xn4, r_in4, r_ddn4, r_vn4, r_dle4, r_dgeu4;
    logic signed [31:0] r_dd4, r_v4;
    // stage 5
    logic [94:0] r_xxm5, r_xxr5, r_iix5, r_ixr5;
    logic [63:0] r_wl5, r_wh5;
    logic [48:0] r_w325;
    logic [63:0] r_w5;
    logic        r_wn5;
    logic [BASE_W-1:0] r_mg5;
    logic [62:0] r_xidd5;
    logic [63:0] r_xv5;
    logic [31:0] r_add5;
    logic        r_xn5, r_in5, r_ddn5, r_vn5, r_dle5, r_dgeu5;
    logic signed [31:0] r_dd5, r_v5;
    logic [31:0] r_ai3, r_ai4, r_ai5;
    // stage 6
    logic [95:0] n_a6, n_b6, n_inner6;
    logic        n_innern6;
    logic [95:0] r_inner6, r_wax6;
    logic        r_innern6;
    logic [63:0] r_ll6;
    logic [48:0] r_lh6;
    logic [33:0] r_hh6;
    logic [94:0] r_xxm6, r_iix6, r_ixr6;
    logic [63:0] r_w6, r_xv6;
    logic        r_wn6;
    logic [BASE_W-1:0] r_mg6;
    logic [31:0] r_ai6, r_add6;
    logic        r_xn6, r_in6, r_ddn6, r_vn6, r_dle6, r_dgeu6;
    logic signed [31:0] r_dd6, r_v6;
    // stage 7
    logic [63:0] r_p07, r_p17, r_p27;
    logic [DEN_W-1:0] r_w32sq7;
    logic        r_innern7;
    logic [95:0] r_wax7;
    logic [94:0] r_xxm7, r_iix7, r_ixr7;
    logic [63:0] r_w7, r_xv7;
    logic        r_wn7;
    logic [BASE_W-1:0] r_mg7;
    logic [31:0] r_add7;
    logic        r_xn7, r_in7, r_ddn7, r_vn7, r_dle7, r_dgeu7;
    logic signed [31:0] r_dd7, r_v7;

    logic [NUM_W-1:0] n_num0;
    t_div_in n_div_a, n_div_b, n_div_c;
    logic signed [Q_W-1:0] w_qa, w_qb, w_qc;

    t_side n_fs;
    logic signed [65:0] n_pr_w, n_mr_w, n_cr_w;
    logic signed [OUT_W-1:0] n_pr, n_mr, n_cr;

    assign adv             = !r_o_vld || i_m_axis_tready;
    assign o_s_axis_tready = adv;
    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {r_o_cr, r_o_mr, r_o_pr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_gravity <= RST_GRAVITY;
            r_mass    <= RST_MASS;
            r_res     <= RST_RESISTANCE;
            r_offset  <= RST_OFFSET;
            r_lfar    <= RST_L_FAR;
            r_xi      <= RST_XI;
            r_upper   <= RST_UPPER;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MODE:       r_mode    <= i_cfg_wdata[0];
                CFG_GRAVITY:    r_gravity <= i_cfg_wdata;
                CFG_MASS:       r_mass    <= i_cfg_wdata;
                CFG_RESISTANCE: r_res     <= i_cfg_wdata;
                CFG_OFFSET:     r_offset  <= i_cfg_wdata;
                CFG_L_FAR:      r_lfar    <= i_cfg_wdata;
                CFG_XI:         r_xi      <= i_cfg_wdata;
                CFG_UPPER:      r_upper   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_o_vld <= 1'b0;
            for (int k = 0; k < SIDE_LEN; k++) begin
                r_svld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld     <= {r_vld[6:1], i_s_axis_tvalid};
            r_svld[0] <= r_vld[7];
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_svld[k] <= r_svld[k-1];
            end
            r_o_vld <= r_svld[SIDE_LEN-1];
        end
    end

    always_comb begin
        n_x2 = $signed({2'b00, r_offset}) + 33'(r_d1);
    end

    always_comb begin
        n_xi24 = 64'({r_xi, 24'd0});
        n_lx4  = {1'b0, r_lx3};
        if (!r_xn3) begin
            n_w4  = n_xi24 + n_lx4;
            n_wn4 = 1'b0;
        end else if (n_xi24 >= n_lx4) begin
            n_w4  = n_xi24 - n_lx4;
            n_wn4 = 1'b0;
        end else begin
            n_w4  = n_lx4 - n_xi24;
            n_wn4 = 1'b1;
        end
    end

    always_comb begin
        n_a6 = 96'({r_xidd5, 24'd0});
        n_b6 = 96'(r_xxr5);
        if (r_ddn5) begin
            n_inner6  = n_a6 + n_b6;
            n_innern6 = 1'b1;
        end else if (n_a6 >= n_b6) begin
            n_inner6  = n_a6 - n_b6;
            n_innern6 = 1'b0;
        end else begin
            n_inner6  = n_b6 - n_a6;
            n_innern6 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d1  <= i_s_axis_tdata[31:0];
            r_dd1 <= i_s_axis_tdata[63:32];
            r_i1  <= i_s_axis_tdata[95:64];
            r_v1  <= i_s_axis_tdata[127:96];

            r_ax2   <= n_x2[32] ? 32'(-n_x2) : n_x2[31:0];
            r_xn2   <= n_x2[32];
            r_ai2   <= f_abs32(r_i1);
            r_in2   <= r_i1[31];
            r_add2  <= f_abs32(r_dd1);
            r_ddn2  <= r_dd1[31];
            r_av2   <= f_abs32(r_v1);
            r_vn2   <= r_v1[31];
            r_dle2  <= r_d1[31] || (r_d1 == 32'sd0);
            r_dgeu2 <= r_d1 >= $signed({1'b0, r_upper});
            r_dd2   <= r_dd1;
            r_v2    <= r_v1;

            r_xx3   <= 64'(r_ax2) * 64'(r_ax2);
            r_ii3   <= 64'(r_ai2) * 64'(r_ai2);
            r_xv3   <= 64'(r_ax2) * 64'(r_av2);
            r_ix3   <= 64'(r_ai2) * 64'(r_ax2);
            r_lx3   <= 63'(r_lfar) * 63'(r_ax2);
            r_xidd3 <= 63'(r_xi) * 63'(r_add2);
            r_mg3   <= 62'(r_mass) * 62'(r_gravity);
            r_ax3   <= r_ax2;
            r_ai3   <= r_ai2;
            r_add3  <= r_add2;
            r_xn3   <= r_xn2;
            r_in3   <= r_in2;
            r_ddn3  <= r_ddn2;
            r_vn3   <= r_vn2;
            r_dle3  <= r_dle2;
            r_dgeu3 <= r_dgeu2;
            r_dd3   <= r_dd2;
            r_v3    <= r_v2;

            r_w4     <= n_w4;
            r_wn4    <= n_wn4;
            r_xxm_l4 <= 63'(r_xx3[31:0]) * 63'(r_mass);
            r_xxm_h4 <= 63'(r_xx3[63:32]) * 63'(r_mass);
            r_xxr_l4 <= 63'(r_xx3[31:0]) * 63'(r_res);
            r_xxr_h4 <= 63'(r_xx3[63:32]) * 63'(r_res);
            r_iix_l4 <= 63'(r_ii3[31:0]) * 63'(r_xi);
            r_iix_h4 <= 63'(r_ii3[63:32]) * 63'(r_xi);
            r_ixr_l4 <= 63'(r_ix3[31:0]) * 63'(r_res);
            r_ixr_h4 <= 63'(r_ix3[63:32]) * 63'(r_res);
            r_mg4    <= BASE_W'((r_mg3 + 62'd8388608) >> 24);
            r_xidd4  <= r_xidd3;
            r_xv4    <= r_xv3;
            r_ax4    <= r_ax3;
            r_ai4    <= r_ai3;
            r_add4   <= r_add3;
            r_xn4    <= r_xn3;
            r_in4    <= r_in3;
            r_ddn4   <= r_ddn3;
            r_vn4    <= r_vn3;
            r_dle4   <= r_dle3;
            r_dgeu4  <= r_dgeu3;
            r_dd4    <= r_dd3;
            r_v4     <= r_v3;

            r_xxm5  <= (95'(r_xxm_h4) << 32) + 95'(r_xxm_l4);
            r_xxr5  <= (95'(r_xxr_h4) << 32) + 95'(r_xxr_l4);
            r_iix5  <= (95'(r_iix_h4) << 32) + 95'(r_iix_l4);
            r_ixr5  <= (95'(r_ixr_h4) << 32) + 95'(r_ixr_l4);
            r_wl5   <= 64'(r_w4[31:0]) * 64'(r_ax4);
            r_wh5   <= 64'(r_w4[63:32]) * 64'(r_ax4);
            r_w325  <= 49'((65'(r_w4) + 65'd32768) >> 16);
            r_w5    <= r_w4;
            r_wn5   <= r_wn4;
            r_mg5   <= r_mg4;
            r_xidd5 <= r_xidd4;
            r_xv5   <= r_xv4;
            r_ai5   <= r_ai4;
            r_add5  <= r_add4;
            r_xn5   <= r_xn4;
            r_in5   <= r_in4;
            r_ddn5  <= r_ddn4;
            r_vn5   <= r_vn4;
            r_dle5  <= r_dle4;
            r_dgeu5 <= r_dgeu4;
            r_dd5   <= r_dd4;
            r_v5    <= r_v4;

            r_inner6  <= n_inner6;
            r_innern6 <= n_innern6;
            r_wax6    <= (96'(r_wh5) << 32) + 96'(r_wl5);
            r_ll6     <= 64'(r_w325[31:0]) * 64'(r_w325[31:0]);
            r_lh6     <= 49'(r_w325[31:0]) * 49'(r_w325[48:32]);
            r_hh6     <= 34'(r_w325[48:32]) * 34'(r_w325[48:32]);
            r_xxm6    <= r_xxm5;
            r_iix6    <= r_iix5;
            r_ixr6    <= r_ixr5;
            r_w6      <= r_w5;
            r_wn6     <= r_wn5;
            r_xv6     <= r_xv5;
            r_mg6     <= r_mg5;
            r_ai6     <= r_ai5;
            r_add6    <= r_add5;
            r_xn6     <= r_xn5;
            r_in6     <= r_in5;
            r_ddn6    <= r_ddn5;
            r_vn6     <= r_vn5;
            r_dle6    <= r_dle5;
            r_dgeu6   <= r_dgeu5;
            r_dd6     <= r_dd5;
            r_v6      <= r_v5;

            r_p07     <= 64'(r_inner6[31:0]) * 64'(r_ai6);
            r_p17     <= 64'(r_inner6[63:32]) * 64'(r_ai6);
            r_p27     <= 64'(r_inner6[95:64]) * 64'(r_ai6);
            r_w32sq7  <= DEN_W'(r_ll6) + (DEN_W'(r_lh6) << 33) + (DEN_W'(r_hh6) << 64);
            r_innern7 <= r_innern6;
            r_wax7    <= r_wax6;
            r_xxm7    <= r_xxm6;
            r_iix7    <= r_iix6;
            r_ixr7    <= r_ixr6;
            r_w7      <= r_w6;
            r_wn7     <= r_wn6;
            r_xv7     <= r_xv6;
            r_mg7     <= r_mg6;
            r_add7    <= r_add6;
            r_xn7     <= r_xn6;
            r_in7     <= r_in6;
            r_ddn7    <= r_ddn6;
            r_vn7     <= r_vn6;
            r_dle7    <= r_dle6;
            r_dgeu7   <= r_dgeu6;
            r_dd7     <= r_dd6;
            r_v7      <= r_v6;

            r_side[0] <= n_side;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_side[k] <= r_side[k-1];
            end

            r_o_pr <= n_pr;
            r_o_mr <= n_mr;
            r_o_cr <= n_cr;
        end
    end

    always_comb begin
        n_num0 = NUM_W'(r_p07) + (NUM_W'(r_p17) << 32) + (NUM_W'(r_p27) << 64);
        if (!r_mode) begin
            n_div_a.num = NUM_W'(r_iix7) << 24;
            n_div_a.den = DEN_W'(r_xxm7) << 1;
            n_div_a.neg = 1'b0;
            n_div_b.num = n_num0;
            n_div_b.den = DEN_W'(r_wax7);
            n_div_b.neg = (r_innern7 ^ r_in7) ^ (r_wn7 ^ r_xn7);
            n_div_c.num = NUM_W'(r_xv7) << 24;
            n_div_c.den = DEN_W'(r_w7);
            n_div_c.neg = (r_xn7 ^ r_vn7) ^ r_wn7;
        end else begin
            n_div_a.num = NUM_W'(r_iix7) << 16;
            n_div_a.den = r_w32sq7 << 1;
            n_div_a.neg = 1'b0;
            n_div_b.num = NUM_W'(r_add7) << 24;
            n_div_b.den = DEN_W'(r_mass);
            n_div_b.neg = r_ddn7;
            n_div_c.num = NUM_W'(r_ixr7);
            n_div_c.den = DEN_W'(r_w7);
            n_div_c.neg = (r_in7 ^ r_xn7) ^ r_wn7;
        end
        n_div_a.zero = (n_div_a.num == '0);
        n_div_b.zero = (n_div_b.num == '0);
        n_div_c.zero = (n_div_c.num == '0);

        n_side.mode   = r_mode;
        n_side.dle0   = r_dle7;
        n_side.dgeu   = r_dgeu7;
        n_side.dd     = r_dd7;
        n_side.base_m = r_mode ? r_mg7 : BASE_W'(r_gravity);
        n_side.v      = r_v7;
    end

    mpd_div u_div_a (.i_clk(i_clk), .i_en(adv), .i_div(n_div_a), .o_quot(w_qa));
    mpd_div u_div_b (.i_clk(i_clk), .i_en(adv), .i_div(n_div_b), .o_quot(w_qb));
    mpd_div u_div_c (.i_clk(i_clk), .i_en(adv), .i_div(n_div_c), .o_quot(w_qc));

    always_comb begin
        n_fs   = r_side[SIDE_LEN-1];
        n_mr_w = $signed({28'd0, n_fs.base_m}) - 66'(w_qa);
        if (!n_fs.mode) begin
            n_pr_w = 66'($signed(n_fs.dd));
            n_cr_w = 66'(w_qb) + 66'(w_qc);
        end else begin
            n_pr_w = 66'(w_qb);
            n_cr_w = 66'($signed(n_fs.v)) - 66'(w_qc);
        end
        n_pr = f_sat(n_pr_w);
        n_mr = f_sat(n_mr_w);
        n_cr = f_sat(n_cr_w);
        // The ball rests against an end stop instead of moving through it.
        if (n_fs.dle0 && (n_pr < 0)) begin
            n_pr = '0;
            if (n_mr < 0) begin
                n_mr = '0;
            end
        end else if (n_fs.dgeu && (n_pr > 0)) begin
            n_pr = '0;
            if (n_mr > 0) begin
                n_mr = '0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/mpd_chk.sv
// Port-level checks for the maglev plant derivative block, with the bind
// that attaches them to the top level. Depends on maglev_plant_derivative.
`default_nettype none

module mpd_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [143:0] o_m_axis_tdata
);

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while the output item is stalled");

    a_free_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("input refused while the pipeline can advance");

    a_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled output item changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind maglev_plant_derivative mpd_chk u_mpd_chk (.*);

`default_nettype wire
